### design/apc_pkg.sv
`default_nettype none
package apc_pkg;

    localparam int DEFAULT_MAX_CLASSES = 4;
    localparam int DIV_STEPS = 24;
    localparam logic [15:0] RELIABLE_COUNT = 16'd40;
    localparam logic [11:0] DIST_RESET = 12'd32;
    localparam logic [2:0] NCLASS_RESET = 3'd2;
    // exact floor(x / 100) for x below 2^24: x * ceil(2^31 / 100) >> 31
    localparam logic [24:0] RECIP_100 = 25'd21474837;
    localparam int RECIP_SHIFT = 31;

    localparam logic [2:0] REG_NUM_CLASSES = 3'd0;
    localparam logic [2:0] REG_METHOD = 3'd1;
    localparam logic [2:0] REG_BOUND_MODE = 3'd2;
    localparam logic [2:0] REG_DISTANCE = 3'd3;
    localparam logic [2:0] REG_THRESHOLD_0 = 3'd4;
    localparam logic [2:0] REG_THRESHOLD_1 = 3'd5;
    localparam logic [2:0] REG_THRESHOLD_2 = 3'd6;

    localparam logic [1:0] METHOD_ADAPTIVE = 2'd0;
    localparam logic [1:0] METHOD_FIXED = 2'd1;
    localparam logic [1:0] METHOD_MEASURED = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RANGE,
        KIND_MEASURED
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CLEAR,
        ST_RNG_A,
        ST_RNG_B,
        ST_CHK,
        ST_DECIDE,
        ST_EVAL,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic rng_a;
        logic rng_b;
        logic chk;
        logic shift;
        logic next_idx;
        logic hit;
        logic hit_from_idx;
        logic rd_hit;
        logic mul;
        logic div_init;
        logic div_step;
        logic write;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] method;
        logic restart;
        logic idx_zero;
        logic idx_last;
        logic cls_last;
        logic pfix;
        logic pin;
        logic l_take;
        logic h_take;
        logic l_meas;
        logic div_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### design/apc_in_if.sv
`default_nettype none
interface apc_in_if;
    logic valid;
    logic ready;
    logic [15:0] pulse_len;
    logic restart;
    modport source (output valid, output pulse_len, output restart, input ready);
    modport sink (input valid, input pulse_len, input restart, output ready);
endinterface
`default_nettype wire

### design/apc_out_if.sv
`default_nettype none
interface apc_out_if;
    logic valid;
    logic ready;
    logic recognised;
    logic [1:0] pulse_class;
    logic [15:0] class_average;
    modport source (output valid, output recognised, output pulse_class,
                    output class_average, input ready);
    modport sink (input valid, input recognised, input pulse_class,
                  input class_average, output ready);
endinterface
`default_nettype wire

### design/apc_dp.sv
`default_nettype none
module apc_dp #(
    parameter int MAX_CLASSES = apc_pkg::DEFAULT_MAX_CLASSES
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_idx,
    input  wire logic [15:0]     i_cfg_wdata,
    input  wire logic [15:0]     i_pulse_len,
    input  wire logic            i_restart,
    input  wire apc_pkg::t_cmd   i_cmd,
    output apc_pkg::t_status     o_status,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_recognised,
    output logic [1:0]           o_pulse_class,
    output logic [15:0]          o_class_average
);
    import apc_pkg::*;

    localparam int CW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;

    // configuration
    logic [2:0]  r_nclass;
    logic [1:0]  r_method;
    logic        r_bmode;
    logic [11:0] r_dist;
    logic [15:0] r_thr0, r_thr1, r_thr2;

    // per class statistics
    logic [15:0] r_min [MAX_CLASSES];
    logic [15:0] r_max [MAX_CLASSES];
    logic [15:0] r_cnt [MAX_CLASSES];
    logic [23:0] r_avg [MAX_CLASSES];

    // item and walk state
    logic [15:0] r_p;
    logic        r_restart;
    logic [CW-1:0] r_idx, r_cls, r_hcls;
    logic        r_hit;
    logic [23:0] r_lo_num, r_hi_num;
    logic [15:0] r_flo, r_fhi;
    t_kind       r_pk, r_lk;
    logic signed [16:0] r_pd, r_ld;
    logic        r_pfix, r_pin;

    // average update
    logic [39:0] r_prod;
    logic [16:0] r_rem, r_div;
    logic [23:0] r_quo;
    logic [4:0]  r_step;

    // output register
    logic        r_ovalid, r_orec;
    logic [1:0]  r_ocls;
    logic [15:0] r_oavg;

    function automatic logic [15:0] thr_at(input logic [3:0] k, input logic [15:0] t0,
                                           input logic [15:0] t1, input logic [15:0] t2);
        logic [15:0] v;
        case (k)
            4'd0:    v = t0;
            4'd1:    v = t1;
            4'd2:    v = t2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] div100_clamp(input logic [23:0] x);
        logic [48:0] pr;
        logic [17:0] q;
        pr = 49'(x) * 49'(RECIP_100);
        q = pr[RECIP_SHIFT+17:RECIP_SHIFT];
        return (q > 18'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // effective class count
    logic [3:0] nc, n_eff, n_last, idx_ext, cls_ext;
    always_comb begin
        nc = {1'b0, r_nclass};
        if (nc < 4'd2) n_eff = 4'd2;
        else if (nc > 4'(MAX_CLASSES)) n_eff = 4'(MAX_CLASSES);
        else n_eff = nc;
        n_last = n_eff - 4'd1;
        idx_ext = 4'(r_idx);
        cls_ext = 4'(r_cls);
    end

    // single stats read port
    logic [CW-1:0] rd_idx;
    logic [15:0] rd_min, rd_max, rd_cnt;
    logic [23:0] rd_avg;
    always_comb begin
        rd_idx = i_cmd.rd_hit ? r_hcls : r_idx;
        rd_min = r_min[rd_idx];
        rd_max = r_max[rd_idx];
        rd_cnt = r_cnt[rd_idx];
        rd_avg = r_avg[rd_idx];
    end

    // fixed range numerators
    logic [15:0] ta, tb;
    logic [23:0] lo_num, hi_num;
    always_comb begin
        ta = thr_at(idx_ext - 4'd1, r_thr0, r_thr1, r_thr2);
        tb = thr_at(idx_ext, r_thr0, r_thr1, r_thr2);
        if (idx_ext == 4'd0) begin
            lo_num = 24'(tb) * 24'd51;
            hi_num = 24'(tb) * 24'd96;
        end else if (idx_ext == n_last) begin
            lo_num = 24'(thr_at(n_eff - 4'd2, r_thr0, r_thr1, r_thr2)) * 24'd104;
            hi_num = 24'(thr_at(n_eff - 4'd2, r_thr0, r_thr1, r_thr2)) * 24'd156;
        end else begin
            lo_num = 24'(ta) * 24'd92 + 24'(tb) * 24'd8;
            hi_num = 24'(ta) * 24'd8 + 24'(tb) * 24'd92;
        end
    end

    // probe of one class
    logic [16:0] m_lo, m_hi, avg_int;
    logic        fix_hit, in_win;
    t_kind       pk;
    logic signed [16:0] pd;
    always_comb begin
        fix_hit = (r_p >= r_flo) && (r_p <= r_fhi);
        in_win = (r_p >= rd_min) && (r_p <= rd_max);
        avg_int = {1'b0, rd_avg[23:8]};
        if (!r_bmode) begin
            m_lo = ({1'b0, rd_min} > 17'(r_dist)) ? {1'b0, rd_min} - 17'(r_dist) : 17'd0;
            m_hi = {1'b0, rd_max} + 17'(r_dist);
        end else begin
            m_lo = (avg_int > 17'(r_dist)) ? avg_int - 17'(r_dist) : 17'd0;
            m_hi = avg_int + 17'(r_dist);
        end
        pk = KIND_NONE;
        pd = '0;
        if (rd_cnt < RELIABLE_COUNT) begin
            pk = fix_hit ? KIND_RANGE : KIND_NONE;
        end else if (in_win) begin
            pk = KIND_MEASURED;
        end else if (r_p < rd_min && {1'b0, r_p} >= m_lo) begin
            pk = KIND_MEASURED;
            pd = $signed({1'b0, r_p}) - $signed({1'b0, rd_min});
        end else if (r_p > rd_max && {1'b0, r_p} <= m_hi) begin
            pk = KIND_MEASURED;
            pd = $signed({1'b0, r_p}) - $signed({1'b0, rd_max});
        end
    end

    logic signed [17:0] dsum;
    logic [17:0] trial;
    logic [40:0] dvd;
    always_comb begin
        dsum = 18'(r_ld) + 18'(r_pd);
        trial = {r_rem, r_quo[23]};
        dvd = 41'(r_prod) + {17'd0, r_p, 8'd0};
    end

    always_comb begin
        o_status.method = r_method;
        o_status.restart = r_restart;
        o_status.idx_zero = (r_idx == '0);
        o_status.idx_last = (idx_ext == n_last);
        o_status.cls_last = (cls_ext == n_last);
        o_status.pfix = r_pfix;
        o_status.pin = r_pin;
        o_status.l_take = (r_lk == KIND_RANGE) || (r_lk == KIND_MEASURED && r_ld < 0);
        o_status.h_take = (r_lk == KIND_MEASURED) &&
                          ((r_pk == KIND_NONE) || (r_pk == KIND_MEASURED && dsum < 0));
        o_status.l_meas = (r_lk == KIND_MEASURED);
        o_status.div_last = (r_step == 5'(DIV_STEPS - 1));
        o_status.out_free = !r_ovalid || i_out_ready;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nclass <= NCLASS_RESET;
            r_method <= METHOD_ADAPTIVE;
            r_bmode <= 1'b0;
            r_dist <= DIST_RESET;
            r_thr0 <= '0;
            r_thr1 <= '0;
            r_thr2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_CLASSES: r_nclass <= i_cfg_wdata[2:0];
                REG_METHOD:      r_method <= i_cfg_wdata[1:0];
                REG_BOUND_MODE:  r_bmode <= i_cfg_wdata[0];
                REG_DISTANCE:    r_dist <= i_cfg_wdata[11:0];
                REG_THRESHOLD_0: r_thr0 <= i_cfg_wdata;
                REG_THRESHOLD_1: r_thr1 <= i_cfg_wdata;
                REG_THRESHOLD_2: r_thr2 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                r_min[i] <= 16'hFFFF;
                r_max[i] <= '0;
                r_cnt[i] <= '0;
                r_avg[i] <= '0;
            end
        end else if (i_cmd.write) begin
            if (rd_min > r_p) r_min[r_hcls] <= r_p;
            if (rd_max < r_p) r_max[r_hcls] <= r_p;
            r_avg[r_hcls] <= r_quo;
            if (rd_cnt != 16'hFFFF) r_cnt[r_hcls] <= rd_cnt + 16'd1;
        end
    end

    // walk and divider state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_idx <= '0;
            r_cls <= '0;
            r_hcls <= '0;
            r_restart <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_cmd.load) begin
                r_p <= i_pulse_len;
                r_restart <= i_restart;
                r_hit <= 1'b0;
                r_idx <= '0;
                r_cls <= '0;
                r_hcls <= '0;
            end
            if (i_cmd.rng_a) begin
                r_lo_num <= lo_num;
                r_hi_num <= hi_num;
            end
            if (i_cmd.rng_b) begin
                r_flo <= div100_clamp(r_lo_num);
                r_fhi <= div100_clamp(r_hi_num);
            end
            if (i_cmd.chk) begin
                r_pk <= pk;
                r_pd <= pd;
                r_pfix <= fix_hit;
                r_pin <= in_win;
            end
            if (i_cmd.shift) begin
                r_lk <= r_pk;
                r_ld <= r_pd;
                r_cls <= r_idx;
            end
            if (i_cmd.next_idx) r_idx <= r_idx + 1'b1;
            if (i_cmd.hit) begin
                r_hit <= 1'b1;
                r_hcls <= i_cmd.hit_from_idx ? r_idx : r_cls;
            end
            if (i_cmd.mul) begin
                r_prod <= 40'(rd_avg) * 40'(rd_cnt);
                r_div <= 17'(rd_cnt) + 17'd1;
            end
            if (i_cmd.div_init) begin
                r_rem <= dvd[40:24];
                r_quo <= dvd[23:0];
                r_step <= '0;
            end
            if (i_cmd.div_step) begin
                if (trial >= 18'(r_div)) begin
                    r_rem <= 17'(trial - 18'(r_div));
                    r_quo <= {r_quo[22:0], 1'b1};
                end else begin
                    r_rem <= trial[16:0];
                    r_quo <= {r_quo[22:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    // output register
    logic [CW:0] hcls_ext;
    assign hcls_ext = {1'b0, r_hcls};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
            r_orec <= r_hit;
            r_ocls <= r_hit ? hcls_ext[1:0] : 2'd0;
            r_oavg <= r_hit ? rd_avg[23:8] : 16'd0;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_recognised = r_orec;
    assign o_pulse_class = r_ocls;
    assign o_class_average = r_oavg;
endmodule
`default_nettype wire

### design/apc_ctrl.sv
`default_nettype none
module apc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire apc_pkg::t_status  i_status,
    output apc_pkg::t_cmd          o_cmd
);
    import apc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (i_status.restart) n_state = ST_CLEAR;
                else if (i_status.method inside {METHOD_ADAPTIVE, METHOD_FIXED,
                                                 METHOD_MEASURED}) n_state = ST_RNG_A;
                else n_state = ST_OUT;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state = ST_OUT;
            end
            ST_RNG_A: begin
                o_cmd.rng_a = 1'b1;
                n_state = ST_RNG_B;
            end
            ST_RNG_B: begin
                o_cmd.rng_b = 1'b1;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                case (i_status.method)
                    METHOD_FIXED: begin
                        if (i_status.pfix) begin
                            o_cmd.hit = 1'b1;
                            o_cmd.hit_from_idx = 1'b1;
                            n_state = ST_MUL;
                        end else if (i_status.idx_last) begin
                            n_state = ST_OUT;
                        end else begin
                            o_cmd.next_idx = 1'b1;
                            n_state = ST_RNG_A;
                        end
                    end
                    METHOD_MEASURED: begin
                        if (i_status.pin) begin
                            o_cmd.hit = 1'b1;
                            o_cmd.hit_from_idx = 1'b1;
                            n_state = ST_OUT;
                        end else if (i_status.idx_last) begin
                            n_state = ST_OUT;
                        end else begin
                            o_cmd.next_idx = 1'b1;
                            n_state = ST_RNG_A;
                        end
                    end
                    default: begin
                        // adaptive: first probe just primes the lower class
                        if (!i_status.idx_zero && i_status.h_take) begin
                            o_cmd.hit = 1'b1;
                            n_state = ST_MUL;
                        end else begin
                            o_cmd.shift = 1'b1;
                            n_state = ST_EVAL;
                        end
                    end
                endcase
            end
            ST_EVAL: begin
                if (i_status.l_take) begin
                    o_cmd.hit = 1'b1;
                    n_state = ST_MUL;
                end else if (i_status.cls_last) begin
                    if (i_status.l_meas) begin
                        o_cmd.hit = 1'b1;
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_OUT;
                    end
                end else begin
                    o_cmd.next_idx = 1'b1;
                    n_state = ST_RNG_A;
                end
            end
            ST_MUL: begin
                o_cmd.rd_hit = 1'b1;
                o_cmd.mul = 1'b1;
                n_state = ST_DINIT;
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.rd_hit = 1'b1;
                o_cmd.write = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.rd_hit = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### design/adaptive_pulse_classifier.sv
`default_nettype none
// adaptive tape pulse classifier
// input channel i_in carries a pulse length and a restart flag; one transfer
// gives exactly one transfer on output channel o_res (recognised, class,
// integer part of that class's running average)
// restart clears all class statistics and answers "not recognised"
// configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata while no item is in flight
// one item at a time: accept and start, then for each class probed the range
// numerators, reciprocal divide by 100, window check and decision, plus in
// adaptive mode the weighing against the class below; on a match with update
// the multiply and the 24-step restoring divide that form the new 16.8
// average; last the output register is loaded
// the output register holds a result until the receiver takes it; the next
// item is accepted meanwhile and parks before its own output load
// synchronous reset returns registers to their defaults and clears stats
module adaptive_pulse_classifier #(
    parameter int MAX_CLASSES = apc_pkg::DEFAULT_MAX_CLASSES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    apc_in_if.sink             i_in,
    apc_out_if.source          o_res
);
    import apc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer for the class walk and the average update
    apc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // statistics, range arithmetic, divider and output register
    apc_dp #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pulse_len     (i_in.pulse_len),
        .i_restart       (i_in.restart),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_recognised    (o_res.recognised),
        .o_pulse_class   (o_res.pulse_class),
        .o_class_average (o_res.class_average)
    );
endmodule
`default_nettype wire

### test/adaptive_pulse_classifier_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module adaptive_pulse_classifier_tb;
    import apc_pkg::*;

    localparam int NCLS = 4;
    localparam int MAX_CYCLES = 1500000;

    typedef struct packed {
        logic        recognised;
        logic [1:0]  pulse_class;
        logic [15:0] class_average;
    } t_result;

    // scoreboard: holds pulse classifier state and the expected answers
    class pulse_scoreboard;
        logic [2:0]  num_classes;
        logic [1:0]  method;
        logic        bound_mode;
        logic [11:0] distance;
        logic [15:0] thresh [3];
        logic [15:0] lo_seen [NCLS];
        logic [15:0] hi_seen [NCLS];
        logic [15:0] count [NCLS];
        logic [23:0] avg [NCLS];
        t_result     pending [$];
        int          errors;

        function void reset_all();
            num_classes = NCLASS_RESET;
            method = METHOD_ADAPTIVE;
            bound_mode = 1'b0;
            distance = DIST_RESET;
            foreach (thresh[i]) thresh[i] = '0;
            clear_stats();
            pending.delete();
            errors = 0;
        endfunction

        function void clear_stats();
            for (int i = 0; i < NCLS; i++) begin
                lo_seen[i] = 16'hffff;
                hi_seen[i] = '0;
                count[i] = '0;
                avg[i] = '0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_NUM_CLASSES: num_classes = v[2:0];
                REG_METHOD:      method = v[1:0];
                REG_BOUND_MODE:  bound_mode = v[0];
                REG_DISTANCE:    distance = v[11:0];
                REG_THRESHOLD_0: thresh[0] = v;
                REG_THRESHOLD_1: thresh[1] = v;
                REG_THRESHOLD_2: thresh[2] = v;
                default: ;
            endcase
        endfunction

        function longint thr_at(int i);
            return (i < 3) ? longint'(thresh[i]) : 0;
        endfunction

        function longint clamp(longint v);
            return (v > 65535) ? 65535 : v;
        endfunction

        function void range_of(int c, int n, output longint lo, output longint hi);
            longint a, b;
            if (c == 0) begin
                lo = thr_at(0) * 51 / 100;
                hi = thr_at(0) * 96 / 100;
            end else if (c == n - 1) begin
                a = thr_at(n - 2);
                lo = clamp(a * 104 / 100);
                hi = clamp(a * 156 / 100);
            end else begin
                a = thr_at(c - 1);
                b = thr_at(c);
                lo = clamp((a * 92 + b * 8) / 100);
                hi = clamp((a * 8 + b * 92) / 100);
            end
        endfunction

        // probe one class: kind of hit and signed gap to the measured edge
        function t_kind probe(longint p, int c, int n, output longint gap);
            longint lo, hi, a, d, mn, mx;
            gap = 0;
            if (count[c] < RELIABLE_COUNT) begin
                range_of(c, n, lo, hi);
                return (p >= lo && p <= hi) ? KIND_RANGE : KIND_NONE;
            end
            d = distance;
            mn = lo_seen[c];
            mx = hi_seen[c];
            if (!bound_mode) begin
                lo = (mn > d) ? mn - d : 0;
                hi = mx + d;
            end else begin
                a = avg[c] >> 8;
                lo = (a > d) ? a - d : 0;
                hi = a + d;
            end
            if (p >= mn && p <= mx) return KIND_MEASURED;
            if (p < mn && p >= lo) begin
                gap = p - mn;
                return KIND_MEASURED;
            end
            if (p > mx && p <= hi) begin
                gap = p - mx;
                return KIND_MEASURED;
            end
            return KIND_NONE;
        endfunction

        function void absorb(longint p, int c);
            longint unsigned cnt, acc;
            cnt = count[c];
            if (lo_seen[c] > p) lo_seen[c] = p[15:0];
            if (hi_seen[c] < p) hi_seen[c] = p[15:0];
            acc = longint'(avg[c]) * cnt + (p << 8);
            avg[c] = 24'(acc / (cnt + 1));
            if (count[c] != 16'hffff) count[c]++;
        endfunction

        function bit adaptive_pick(longint p, int n, output int cls);
            longint lgap, hgap;
            t_kind lk, hk;
            int c;
            bit hit;
            c = 0;
            hit = 0;
            lk = probe(p, 0, n, lgap);
            forever begin
                if (lk == KIND_RANGE || (lk == KIND_MEASURED && lgap < 0)) begin
                    hit = 1;
                    break;
                end
                if (c == n - 1) break;
                hk = probe(p, c + 1, n, hgap);
                if (lk == KIND_MEASURED &&
                    (hk == KIND_NONE || (hk == KIND_MEASURED && lgap < -hgap))) begin
                    hit = 1;
                    break;
                end
                lgap = hgap;
                lk = hk;
                c++;
            end
            if (!hit && lk == KIND_MEASURED) hit = 1;
            cls = c;
            return hit;
        endfunction

        // note an accepted pulse and queue its expected answer
        function void note_pulse(logic [15:0] raw, logic restart);
            t_result r;
            longint p, lo, hi;
            int n, c;
            bit hit;
            r = '0;
            p = raw;
            c = 0;
            hit = 0;
            if (restart) begin
                clear_stats();
                pending.push_back(r);
                return;
            end
            n = num_classes;
            if (n < 2) n = 2;
            if (n > NCLS) n = NCLS;
            if (method == METHOD_ADAPTIVE) begin
                hit = adaptive_pick(p, n, c);
                if (hit) absorb(p, c);
            end else if (method == METHOD_FIXED) begin
                for (int i = 0; i < n && !hit; i++) begin
                    range_of(i, n, lo, hi);
                    if (p >= lo && p <= hi) begin
                        hit = 1;
                        c = i;
                    end
                end
                if (hit) absorb(p, c);
            end else if (method == METHOD_MEASURED) begin
                for (int i = 0; i < n && !hit; i++) begin
                    if (p >= lo_seen[i] && p <= hi_seen[i]) begin
                        hit = 1;
                        c = i;
                    end
                end
            end
            if (hit) begin
                r.recognised = 1'b1;
                r.pulse_class = c[1:0];
                r.class_average = avg[c][23:8];
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result rec=%0d cls=%0d avg=%0d",
                             got.recognised, got.pulse_class, got.class_average);
                return;
            end
            exp_r = pending.pop_front();
            if (got.recognised !== exp_r.recognised ||
                got.pulse_class !== exp_r.pulse_class ||
                got.class_average !== exp_r.class_average) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp rec=%0d cls=%0d avg=%0d got rec=%0d cls=%0d avg=%0d",
                             exp_r.recognised, exp_r.pulse_class, exp_r.class_average,
                             got.recognised, got.pulse_class, got.class_average);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    apc_in_if  pulse_ch ();
    apc_out_if res_ch ();

    adaptive_pulse_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (pulse_ch.sink),
        .o_res       (res_ch.source)
    );

    always #4 i_clk = ~i_clk;

    pulse_scoreboard sb;
    int  send_idle_pct = 0;   // chance in percent of an idle cycle on the pulse side
    int  stall_pct = 0;       // chance in percent of holding off a result
    int  cycles = 0;
    bit  timed_out = 0;

    initial begin
        pulse_ch.valid = 1'b0;
        pulse_ch.pulse_len = '0;
        pulse_ch.restart = 1'b0;
        res_ch.ready = 1'b0;
        sb = new();
        sb.reset_all();
    end

    // receiver side: random stalls, check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result({res_ch.recognised, res_ch.pulse_class, res_ch.class_average});
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES && !timed_out) begin
            timed_out = 1;
            $display("FAIL adaptive_pulse_classifier");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one pulse transfer, with random idle cycles before it
    task automatic send_pulse(logic [15:0] raw, logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            pulse_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pulse_ch.valid <= 1'b1;
        pulse_ch.pulse_len <= raw;
        pulse_ch.restart <= restart;
        do @(posedge i_clk); while (!pulse_ch.ready);
        sb.note_pulse(raw, restart);
    endtask

    // drop valid and wait for every expected result, then the latency tail
    task automatic drain();
        @(posedge i_clk);
        pulse_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_thresholds(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        cfg_write(REG_THRESHOLD_0, a);
        cfg_write(REG_THRESHOLD_1, b);
        cfg_write(REG_THRESHOLD_2, c);
    endtask

    // pulse below, above or at a random threshold so statistics build up, with noise
    function automatic logic [15:0] pick_pulse();
        int k;
        longint t;
        k = $urandom_range(99);
        if (k < 15) return 16'($urandom);
        if (k < 20) return (k < 18) ? 16'hffff : 16'h0000;
        t = sb.thresh[$urandom_range(2)];
        case ($urandom_range(2))
            0: return 16'(t * 70 / 100 + $urandom_range(31));
            1: return 16'((t * 130 / 100 > 65535) ? 65535 - $urandom_range(63)
                                                  : t * 130 / 100 - $urandom_range(31));
            default: return 16'(t + $urandom_range(63) - 32);
        endcase
    endfunction

    task automatic random_phase(int items, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < items; i++)
            send_pulse(pick_pulse(), $urandom_range(99) == 0);
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, zero thresholds, extremes
        send_pulse(16'h0000, 1'b0);
        send_pulse(16'hffff, 1'b0);
        send_pulse(16'h0001, 1'b1);
        drain();

        // fixed ranges with update, four classes, top threshold saturates
        cfg_write(REG_NUM_CLASSES, 16'd4);
        cfg_write(REG_METHOD, {14'd0, METHOD_FIXED});
        set_thresholds(16'd1000, 16'd3000, 16'hffff);
        send_pulse(16'd700, 1'b0);
        send_pulse(16'd2000, 1'b0);
        send_pulse(16'd5000, 1'b0);
        send_pulse(16'hffff, 1'b0);
        send_pulse(16'd990, 1'b0);
        send_pulse(16'd3, 1'b0);
        drain();

        // measured only, then unused method, then out of range class counts
        cfg_write(REG_METHOD, {14'd0, METHOD_MEASURED});
        send_pulse(16'd2000, 1'b0);
        send_pulse(16'd100, 1'b0);
        drain();
        cfg_write(REG_METHOD, 16'd3);
        send_pulse(16'd2000, 1'b0);
        drain();
        cfg_write(REG_METHOD, {14'd0, METHOD_ADAPTIVE});
        cfg_write(REG_NUM_CLASSES, 16'd0);
        send_pulse(16'd700, 1'b0);
        drain();
        cfg_write(REG_NUM_CLASSES, 16'd7);
        send_pulse(16'd700, 1'b0);
        drain();

        // adaptive, bound by distance: push class 0 past reliable count
        cfg_write(REG_NUM_CLASSES, 16'd3);
        cfg_write(REG_DISTANCE, 16'd4095);
        set_thresholds(16'd200, 16'd600, 16'd0);
        send_idle_pct = 0;
        for (int i = 0; i < 45; i++) send_pulse(16'(150 + $urandom_range(20)), 1'b0);
        // far below: lower bound clamps at zero
        send_pulse(16'd0, 1'b0);
        send_pulse(16'd50000, 1'b0);
        drain();

        // random phases across settings and idle patterns
        cfg_write(REG_DISTANCE, 16'd0);
        cfg_write(REG_BOUND_MODE, 16'd1);
        set_thresholds(16'd300, 16'd900, 16'd2000);
        random_phase(120, 0, 0);

        cfg_write(REG_NUM_CLASSES, 16'd4);
        cfg_write(REG_BOUND_MODE, 16'd0);
        cfg_write(REG_DISTANCE, 16'd40);
        random_phase(120, 72, 0);

        cfg_write(REG_METHOD, {14'd0, METHOD_FIXED});
        set_thresholds(16'd20000, 16'd40000, 16'd60000);
        random_phase(100, 0, 72);

        cfg_write(REG_METHOD, {14'd0, METHOD_MEASURED});
        random_phase(60, 38, 38);

        cfg_write(REG_METHOD, {14'd0, METHOD_ADAPTIVE});
        cfg_write(REG_NUM_CLASSES, 16'd2);
        cfg_write(REG_BOUND_MODE, 16'd1);
        cfg_write(REG_DISTANCE, 16'd4095);
        set_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
        random_phase(150, 38, 38);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS adaptive_pulse_classifier");
        end else begin
            $display("FAIL adaptive_pulse_classifier");
        end
        $finish;
    end
endmodule
`default_nettype wire
